// ===== sv/rkw_pkg.sv =====
// shared constants, types and arithmetic helpers of the resampling kernel weight block
`timescale 1ns / 1ps
`default_nettype none

package rkw_pkg;

	// phase grid: PHASES steps per sample, kept a power of two so all divisions are shifts
	localparam int PHASE_LOG = 6;
	localparam int PHASES    = 1 << PHASE_LOG;
	localparam int FRAC_BITS = 14;

	// port widths fixed by the interface
	localparam int PHASE_W  = 7;
	localparam int WEIGHT_W = 16;
	localparam int COUNT_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 2;

	// internal widths
	localparam int P_W   = PHASE_LOG + 1;           // 0..PHASES
	localparam int SQ_W  = 2 * P_W;                 // squares
	localparam int CU_W  = 3 * P_W;                 // cubes and cross products
	localparam int NUM_W = 3 * PHASE_LOG + 5;       // signed cubic numerators
	localparam int SC_W  = NUM_W + FRAC_BITS;       // numerators scaled to weight units

	// cubic denominator is 2 * PHASES^3
	localparam int CUBE_SHIFT = 3 * PHASE_LOG + 1;

	localparam logic signed [NUM_W-1:0] CUBE_BASE = NUM_W'(longint'(2) << (3 * PHASE_LOG));
	localparam logic signed [SC_W-1:0]  ONE_SC    = SC_W'(longint'(1) << FRAC_BITS);
	localparam logic signed [SC_W-1:0]  W_MAX     =
		SC_W'((longint'(1) << (WEIGHT_W - 1)) - 1);
	localparam logic signed [SC_W-1:0]  W_MIN     = -W_MAX - SC_W'(1);

	// kernel mode register codes; the unused code behaves as bilinear
	localparam logic [1:0] KM_NEAREST  = 2'd0;
	localparam logic [1:0] KM_BILINEAR = 2'd1;
	localparam logic [1:0] KM_CUBIC    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_OLD_NEAREST = CFG_IDX_W'(1);

	// tap count codes
	localparam logic [COUNT_W-1:0] TAPS_TWO  = COUNT_W'(2);
	localparam logic [COUNT_W-1:0] TAPS_FOUR = COUNT_W'(4);

	// weight set chosen for one beat
	typedef enum logic [1:0] {
		SEL_LINEAR,
		SEL_STEP,
		SEL_CUBIC
	} wsel_t;

	// control that travels with a beat down the pipeline
	typedef struct packed {
		wsel_t sel;
		logic  step_first;
	} item_ctrl_t;

	// divide by 2^sh, rounding to nearest with ties away from zero
	function automatic logic signed [SC_W-1:0] round_shift(
		input logic signed [SC_W-1:0] num,
		input int sh
	);
		logic signed [SC_W-1:0] half;
		logic signed [SC_W-1:0] mag;
		half = (SC_W'(1) <<< sh) >>> 1;
		mag  = -num;
		if (num >= 0) begin
			round_shift = (num + half) >>> sh;
		end else begin
			round_shift = -((mag + half) >>> sh);
		end
	endfunction

	// clamp to the signed weight range
	function automatic logic signed [WEIGHT_W-1:0] sat_weight(
		input logic signed [SC_W-1:0] w
	);
		logic signed [SC_W-1:0] c;
		c = w;
		if (w > W_MAX) begin
			c = W_MAX;
		end
		if (w < W_MIN) begin
			c = W_MIN;
		end
		sat_weight = c[WEIGHT_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/rkw_cube.sv =====
// two pipeline stages forming the squares, cubes and cross products of p and q
`timescale 1ns / 1ps
`default_nettype none

module rkw_cube (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               valid_in,
	output logic                              ready_up,
	input  wire  [rkw_pkg::P_W-1:0]           p_in,
	input  wire  [rkw_pkg::P_W-1:0]           q_in,
	input  wire  rkw_pkg::item_ctrl_t         ctrl_in,
	output logic                              valid_out,
	input  wire                               ready_down,
	output logic [rkw_pkg::P_W-1:0]           p_out,
	output logic [rkw_pkg::P_W-1:0]           q_out,
	output logic [rkw_pkg::SQ_W-1:0]          p2_out,
	output logic [rkw_pkg::SQ_W-1:0]          q2_out,
	output logic [rkw_pkg::CU_W-1:0]          p3_out,
	output logic [rkw_pkg::CU_W-1:0]          q3_out,
	output logic [rkw_pkg::CU_W-1:0]          pq2_out,
	output logic [rkw_pkg::CU_W-1:0]          qp2_out,
	output rkw_pkg::item_ctrl_t               ctrl_out
);
	import rkw_pkg::*;

	logic              adv_s2, adv_s3;
	logic              valid_s2, valid_s3;
	logic [P_W-1:0]    p_s2, q_s2, p_s3, q_s3;
	logic [SQ_W-1:0]   p2_s2, q2_s2, p2_s3, q2_s3;
	logic [CU_W-1:0]   p3_s3, q3_s3, pq2_s3, qp2_s3;
	item_ctrl_t        ctrl_s2, ctrl_s3;

	// a stage moves when its slot is empty or the next one moves
	assign adv_s3   = !valid_s3 || ready_down;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign ready_up = adv_s2;

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				valid_s2 <= valid_in;
			end
			if (adv_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// squares
	always_ff @(posedge clk) begin
		if (adv_s2 && valid_in) begin
			p_s2    <= p_in;
			q_s2    <= q_in;
			p2_s2   <= SQ_W'(p_in) * SQ_W'(p_in);
			q2_s2   <= SQ_W'(q_in) * SQ_W'(q_in);
			ctrl_s2 <= ctrl_in;
		end
	end

	// cubes and cross products
	always_ff @(posedge clk) begin
		if (adv_s3 && valid_s2) begin
			p_s3    <= p_s2;
			q_s3    <= q_s2;
			p2_s3   <= p2_s2;
			q2_s3   <= q2_s2;
			p3_s3   <= CU_W'(p_s2) * CU_W'(p2_s2);
			q3_s3   <= CU_W'(q_s2) * CU_W'(q2_s2);
			pq2_s3  <= CU_W'(p_s2) * CU_W'(q2_s2);
			qp2_s3  <= CU_W'(q_s2) * CU_W'(p2_s2);
			ctrl_s3 <= ctrl_s2;
		end
	end

	assign valid_out = valid_s3;
	assign p_out     = p_s3;
	assign q_out     = q_s3;
	assign p2_out    = p2_s3;
	assign q2_out    = q2_s3;
	assign p3_out    = p3_s3;
	assign q3_out    = q3_s3;
	assign pq2_out   = pq2_s3;
	assign qp2_out   = qp2_s3;
	assign ctrl_out  = ctrl_s3;

endmodule

`default_nettype wire

// ===== sv/resampling_kernel_weights.sv =====
// top level: tap weight generator for nearest, bilinear and cubic resampling kernels
//
//  channel  | signals                              | dir | accepted when
//  ---------+--------------------------------------+-----+--------------------------
//  in       | in_valid, in_ready, phase            | in  | in_valid && in_ready
//  out      | out_valid, out_ready, weight0..3,    | out | out_valid && out_ready
//           | tap_count, taps_before               |     |
//  cfg      | cfg_valid, cfg_ready, cfg_index,     | in  | cfg_valid && cfg_ready
//           | cfg_data                             |     |
//
// four register stages: phase clamp and mode decode, squares, cubes, then
// numerator assembly with rounding and clamping into the output register.
// one beat per cycle is sustained while out_ready is high, as every stage takes
// a new beat whenever the one after it moves.
// reset clears all valid bits and sets kernel_mode to bilinear, old_nearest to 0.
// a stall at the output holds each full stage; empty stages keep filling behind it.
`timescale 1ns / 1ps
`default_nettype none

module resampling_kernel_weights (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    in_valid,
	output logic                                   in_ready,
	input  wire  [rkw_pkg::PHASE_W-1:0]            phase,
	output logic                                   out_valid,
	input  wire                                    out_ready,
	output logic signed [rkw_pkg::WEIGHT_W-1:0]    weight0,
	output logic signed [rkw_pkg::WEIGHT_W-1:0]    weight1,
	output logic signed [rkw_pkg::WEIGHT_W-1:0]    weight2,
	output logic signed [rkw_pkg::WEIGHT_W-1:0]    weight3,
	output logic [rkw_pkg::COUNT_W-1:0]            tap_count,
	output logic                                   taps_before,
	input  wire                                    cfg_valid,
	output logic                                   cfg_ready,
	input  wire  [rkw_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire  [rkw_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import rkw_pkg::*;

	logic [1:0]     kernel_mode_q;
	logic           old_nearest_q;

	logic           adv_s1, adv_s4;
	logic           valid_s1, valid_s4;
	logic [P_W-1:0] p_clamp, p_s1, q_s1;
	item_ctrl_t     ctrl_c, ctrl_s1;

	logic              cube_ready, cube_valid;
	logic [P_W-1:0]    p_c, q_c;
	logic [SQ_W-1:0]   p2_c, q2_c;
	logic [CU_W-1:0]   p3_c, q3_c, pq2_c, qp2_c;
	item_ctrl_t        ctrl_cube;

	logic signed [NUM_W-1:0]    n0, n1, n2, n3;
	logic signed [SC_W-1:0]     lin0, lin1;
	logic signed [WEIGHT_W-1:0] w0_c, w1_c, w2_c, w3_c;
	logic [COUNT_W-1:0]         count_c;
	logic                       before_c;

	logic signed [WEIGHT_W-1:0] weight0_s4, weight1_s4, weight2_s4, weight3_s4;
	logic [COUNT_W-1:0]         tap_count_s4;
	logic                       taps_before_s4;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_mode_q <= KM_BILINEAR;
			old_nearest_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_KERNEL_MODE) begin
				kernel_mode_q <= cfg_data[1:0];
			end else if (cfg_index == CFG_OLD_NEAREST) begin
				old_nearest_q <= cfg_data[0];
			end
		end
	end

	// handshake chain
	assign adv_s4   = !valid_s4 || out_ready;
	assign adv_s1   = !valid_s1 || cube_ready;
	assign in_ready = adv_s1;

	// stage 1: clamp phase, decode kernel
	always_comb begin
		if (phase > PHASE_W'(PHASES)) begin
			p_clamp = P_W'(PHASES);
		end else begin
			p_clamp = phase[P_W-1:0];
		end
		if (kernel_mode_q == KM_CUBIC) begin
			ctrl_c.sel = SEL_CUBIC;
		end else if (kernel_mode_q == KM_NEAREST && old_nearest_q) begin
			ctrl_c.sel = SEL_STEP;
		end else begin
			ctrl_c.sel = SEL_LINEAR;
		end
		ctrl_c.step_first = ({1'b0, p_clamp} << 1) <= (P_W + 1)'(PHASES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			p_s1    <= p_clamp;
			q_s1    <= P_W'(PHASES) - p_clamp;
			ctrl_s1 <= ctrl_c;
		end
	end

	// stages 2 and 3: polynomial products
	rkw_cube u_cube (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_in   (valid_s1),
		.ready_up   (cube_ready),
		.p_in       (p_s1),
		.q_in       (q_s1),
		.ctrl_in    (ctrl_s1),
		.valid_out  (cube_valid),
		.ready_down (adv_s4),
		.p_out      (p_c),
		.q_out      (q_c),
		.p2_out     (p2_c),
		.q2_out     (q2_c),
		.p3_out     (p3_c),
		.q3_out     (q3_c),
		.pq2_out    (pq2_c),
		.qp2_out    (qp2_c),
		.ctrl_out   (ctrl_cube)
	);

	// stage 4: numerators, rounding, clamping and weight selection
	always_comb begin
		n0 = -NUM_W'(pq2_c);
		n3 = -NUM_W'(qp2_c);
		n1 = NUM_W'(3) * NUM_W'(p3_c) - ((NUM_W'(5) * NUM_W'(p2_c)) <<< PHASE_LOG)
			+ CUBE_BASE;
		n2 = NUM_W'(3) * NUM_W'(q3_c) - ((NUM_W'(5) * NUM_W'(q2_c)) <<< PHASE_LOG)
			+ CUBE_BASE;
		lin0 = round_shift(SC_W'(q_c) <<< FRAC_BITS, PHASE_LOG);
		lin1 = round_shift(SC_W'(p_c) <<< FRAC_BITS, PHASE_LOG);

		w0_c     = '0;
		w1_c     = '0;
		w2_c     = '0;
		w3_c     = '0;
		count_c  = TAPS_TWO;
		before_c = 1'b0;
		case (ctrl_cube.sel)
			SEL_CUBIC: begin
				w0_c     = sat_weight(round_shift(SC_W'(n0) <<< FRAC_BITS, CUBE_SHIFT));
				w1_c     = sat_weight(round_shift(SC_W'(n1) <<< FRAC_BITS, CUBE_SHIFT));
				w2_c     = sat_weight(round_shift(SC_W'(n2) <<< FRAC_BITS, CUBE_SHIFT));
				w3_c     = sat_weight(round_shift(SC_W'(n3) <<< FRAC_BITS, CUBE_SHIFT));
				count_c  = TAPS_FOUR;
				before_c = 1'b1;
			end
			SEL_STEP: begin
				if (ctrl_cube.step_first) begin
					w0_c = sat_weight(ONE_SC);
				end else begin
					w1_c = sat_weight(ONE_SC);
				end
			end
			default: begin
				w0_c = sat_weight(lin0);
				w1_c = sat_weight(lin1);
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv_s4) begin
			valid_s4 <= cube_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s4 && cube_valid) begin
			weight0_s4     <= w0_c;
			weight1_s4     <= w1_c;
			weight2_s4     <= w2_c;
			weight3_s4     <= w3_c;
			tap_count_s4   <= count_c;
			taps_before_s4 <= before_c;
		end
	end

	assign out_valid   = valid_s4;
	assign weight0     = weight0_s4;
	assign weight1     = weight1_s4;
	assign weight2     = weight2_s4;
	assign weight3     = weight3_s4;
	assign tap_count   = tap_count_s4;
	assign taps_before = taps_before_s4;

endmodule

`default_nettype wire
